>>> design/rlbhc_pkg.sv
// Shared types, constants and the control store of the roll law bank hold controller.
package rlbhc_pkg;

   // Fixed-point thresholds, all Q16
   localparam logic [16:0]        ONE_Q16          = 17'd65536;
   localparam logic [28:0]        HEIGHT_LOW_Q16   = 29'd589824;     // 9 ft
   localparam logic [28:0]        HEIGHT_HIGH_Q16  = 29'd26214400;   // 400 ft
   localparam logic signed [23:0] PITCH_TRIP_Q16   = 24'sd524288;    // 8 deg
   localparam logic [24:0]        BANK_KNEE_Q16    = 25'd2162688;    // 33 deg
   localparam logic signed [27:0] BANK_LIMIT_Q16   = 28'sd4325376;   // 66 deg
   localparam logic signed [24:0] RATE_MAX         = 25'sd8388607;
   localparam logic signed [24:0] RATE_MIN         = -25'sd8388608;
   localparam logic signed [37:0] MIX_MAX          = 38'sd65536;
   localparam logic signed [37:0] MIX_MIN          = -38'sd65536;

   // floor(x / 11) = (x * RECIP_11) >> RECIP_SHIFT for x below 2^27
   localparam logic [27:0]        RECIP_11         = 28'd195225787;
   localparam int                 RECIP_SHIFT      = 31;

   // Configuration register indexes
   localparam logic [2:0] REG_BANK_PROP   = 3'd0;
   localparam logic [2:0] REG_BANK_SECOND = 3'd1;
   localparam logic [2:0] REG_BANK_DEMAND = 3'd2;
   localparam logic [2:0] REG_ROLL_RATE   = 3'd3;
   localparam logic [2:0] REG_WEIGHT_CEIL = 3'd4;

   // Step advance conditions
   localparam logic [1:0] WAIT_NONE = 2'd0;
   localparam logic [1:0] WAIT_REQ  = 2'd1;
   localparam logic [1:0] WAIT_OUT  = 2'd2;

   // Multiplier operand pairs
   localparam logic [2:0] MUL_NONE   = 3'd0;
   localparam logic [2:0] MUL_RECIP  = 3'd1;
   localparam logic [2:0] MUL_RATE   = 3'd2;
   localparam logic [2:0] MUL_DGAIN  = 3'd3;
   localparam logic [2:0] MUL_PGAIN  = 3'd4;
   localparam logic [2:0] MUL_RGAIN  = 3'd5;
   localparam logic [2:0] MUL_WXI    = 3'd6;
   localparam logic [2:0] MUL_WSTICK = 3'd7;

   // Accumulator operations
   localparam logic [1:0] SUM_HOLD = 2'd0;
   localparam logic [1:0] SUM_LOAD = 2'd1;
   localparam logic [1:0] SUM_ADD  = 2'd2;

   // Register write targets
   localparam logic [2:0] DST_NONE    = 3'd0;
   localparam logic [2:0] DST_WEIGHT  = 3'd1;
   localparam logic [2:0] DST_LIMIT   = 3'd2;
   localparam logic [2:0] DST_BANKDEM = 3'd3;
   localparam logic [2:0] DST_XI      = 3'd4;
   localparam logic [2:0] DST_RESULT  = 3'd5;

   localparam int STEP_W = 4;

   typedef struct packed {
      logic [1:0] wait_sel;
      logic [2:0] mul_sel;
      logic [1:0] sum_op;
      logic [2:0] dst;
      logic       restart;
   } ctrl_word_type;

   // Control store: one word per step
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '{wait_sel: WAIT_NONE, mul_sel: MUL_NONE, sum_op: SUM_HOLD,
             dst: DST_NONE, restart: 1'b0};
      unique case (step)
         4'd0:  cw.wait_sel = WAIT_REQ;
         4'd1:  cw.dst      = DST_WEIGHT;
         4'd2:  cw.mul_sel  = MUL_RECIP;
         4'd3:  cw.dst      = DST_LIMIT;
         4'd4:  cw.mul_sel  = MUL_RATE;
         4'd5:  cw.dst      = DST_BANKDEM;
         4'd6:  cw.mul_sel  = MUL_DGAIN;
         4'd7:  begin
            cw.mul_sel = MUL_PGAIN;
            cw.sum_op  = SUM_LOAD;
         end
         4'd8:  begin
            cw.mul_sel = MUL_RGAIN;
            cw.sum_op  = SUM_ADD;
         end
         4'd9:  cw.sum_op   = SUM_ADD;
         4'd10: cw.dst      = DST_XI;
         4'd11: cw.mul_sel  = MUL_WXI;
         4'd12: begin
            cw.mul_sel = MUL_WSTICK;
            cw.sum_op  = SUM_LOAD;
         end
         4'd13: cw.sum_op   = SUM_ADD;
         4'd14: begin
            cw.wait_sel = WAIT_OUT;
            cw.dst      = DST_RESULT;
            cw.restart  = 1'b1;
         end
         default: cw.restart = 1'b1;
      endcase
      return cw;
   endfunction

endpackage

>>> design/roll_law_bank_hold_controller.sv
// Top level: microcoded roll control law with bank hold and mode weight blending.
//
// Usage:
//   Request channel (req_*): one sensor sample per request. A request is taken
//   at a rising edge with req_valid high and req_stall low. req_stall is high
//   while a sample is being worked on.
//   Response channel (rsp_*): one result per request, held in an output
//   register until taken (rsp_valid high, rsp_stall low).
//   The user writes gains and the weight ceiling over the APB-style port only
//   while idle, unenforced. Reads return stored values; pready is always high.
// Timing:
//   A sample walks through a 15-step control program that drives one shared
//   signed multiplier and one accumulator. The output register is loaded at
//   the last step; no new request is taken until the program is back at step
//   0, as the shared multiplier, used seven times per sample, runs serially.
//   A new request is taken while the previous result still waits; the last
//   step holds only if the output register is still full and stalled.
// Reset: clears the mode weight (ground mode), the bank demand, the gains and
//   the output valid, and sets the weight ceiling to 1.0.
module roll_law_bank_hold_controller #(
   parameter int unsigned SAMPLE_PERIOD_Q16 = 1311
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [28:0]        req_radio_height,
   input  logic signed [23:0] req_pitch_angle,
   input  logic signed [24:0] req_bank_angle,
   input  logic signed [21:0] req_roll_rate,
   input  logic signed [17:0] req_stick_deflection,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_aileron_command,
   output logic signed [23:0] rsp_rate_demand,
   output logic signed [23:0] rsp_limiter_term,
   output logic signed [24:0] rsp_bank_demand_out,
   output logic [16:0]        rsp_mode_weight_out,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Weight ramp step is two sample periods; the multiplier sees one period.
   localparam logic [16:0] WEIGHT_STEP = 17'(2 * SAMPLE_PERIOD_Q16);
   localparam logic [15:0] PERIOD_Q16  = 16'(SAMPLE_PERIOD_Q16);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [23:0] bank_prop_gain_ff, bank_second_gain_ff;
   logic signed [23:0] bank_demand_gain_ff, roll_rate_gain_ff;
   logic [16:0]        weight_ceiling_ff;
   logic               cfg_write;
   logic [2:0]         cfg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign cfg_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_prop_gain_ff   <= '0;
         bank_second_gain_ff <= '0;
         bank_demand_gain_ff <= '0;
         roll_rate_gain_ff   <= '0;
         weight_ceiling_ff   <= rlbhc_pkg::ONE_Q16;
      end else if (cfg_write) begin
         unique case (cfg_index)
            rlbhc_pkg::REG_BANK_PROP:   bank_prop_gain_ff   <= $signed(pwdata[23:0]);
            rlbhc_pkg::REG_BANK_SECOND: bank_second_gain_ff <= $signed(pwdata[23:0]);
            rlbhc_pkg::REG_BANK_DEMAND: bank_demand_gain_ff <= $signed(pwdata[23:0]);
            rlbhc_pkg::REG_ROLL_RATE:   roll_rate_gain_ff   <= $signed(pwdata[23:0]);
            rlbhc_pkg::REG_WEIGHT_CEIL: weight_ceiling_ff   <= pwdata[16:0];
            default: ;  // addresses past the register list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         rlbhc_pkg::REG_BANK_PROP:   prdata = 32'(bank_prop_gain_ff);
         rlbhc_pkg::REG_BANK_SECOND: prdata = 32'(bank_second_gain_ff);
         rlbhc_pkg::REG_BANK_DEMAND: prdata = 32'(bank_demand_gain_ff);
         rlbhc_pkg::REG_ROLL_RATE:   prdata = 32'(roll_rate_gain_ff);
         rlbhc_pkg::REG_WEIGHT_CEIL: prdata = {15'd0, weight_ceiling_ff};
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: step counter plus control store
   // ------------------------------------------------------------------
   logic [rlbhc_pkg::STEP_W-1:0] step_ff, step_in;
   rlbhc_pkg::ctrl_word_type     cw;
   logic                         step_go;
   logic                         req_take;
   logic                         rsp_valid_ff, rsp_valid_in;

   assign cw        = rlbhc_pkg::ucode_rom(step_ff);
   assign req_stall = (cw.wait_sel != rlbhc_pkg::WAIT_REQ);
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      case (cw.wait_sel)
         rlbhc_pkg::WAIT_REQ: step_go = req_valid;
         rlbhc_pkg::WAIT_OUT: step_go = ~(rsp_valid_ff & rsp_stall);
         default:             step_go = 1'b1;
      endcase
      if (!step_go) begin
         step_in = step_ff;
      end else if (cw.restart) begin
         step_in = '0;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Captured sample
   // ------------------------------------------------------------------
   logic [28:0]        height_ff;
   logic signed [23:0] pitch_ff;
   logic signed [24:0] bank_ff;
   logic signed [21:0] rate_ff;
   logic signed [17:0] stick_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         height_ff <= req_radio_height;
         pitch_ff  <= req_pitch_angle;
         bank_ff   <= req_bank_angle;
         rate_ff   <= req_roll_rate;
         stick_ff  <= req_stick_deflection;
      end
   end

   // ------------------------------------------------------------------
   // Mode weight ramp and bank magnitude past the limiter knee
   // ------------------------------------------------------------------
   logic [16:0] weight_ff, weight_in;
   logic [18:0] weight_sum;
   logic [16:0] weight_up, weight_down, weight_pick;
   logic        above_low, rise;
   logic [24:0] bank_abs, bank_excess;
   logic [26:0] excess5_ff, excess5_in;

   always_comb begin
      weight_sum  = {2'b00, weight_ff} + {2'b00, WEIGHT_STEP};
      weight_up   = (weight_sum > {2'b00, rlbhc_pkg::ONE_Q16}) ? rlbhc_pkg::ONE_Q16
                                                               : weight_sum[16:0];
      weight_down = (weight_ff > WEIGHT_STEP) ? (weight_ff - WEIGHT_STEP) : '0;
      above_low   = height_ff > rlbhc_pkg::HEIGHT_LOW_Q16;
      rise        = ((weight_ff < rlbhc_pkg::ONE_Q16) && (pitch_ff > rlbhc_pkg::PITCH_TRIP_Q16))
                    || (height_ff > rlbhc_pkg::HEIGHT_HIGH_Q16);
      if (above_low) begin
         weight_pick = rise ? weight_up : weight_ff;
      end else begin
         weight_pick = weight_down;
      end
      // clamp to the override ceiling
      weight_in = (weight_pick > weight_ceiling_ff) ? weight_ceiling_ff : weight_pick;

      // |bank| as unsigned; the most negative code maps to 2^24
      bank_abs    = bank_ff[24] ? (~bank_ff + 25'd1) : bank_ff;
      bank_excess = (bank_abs > rlbhc_pkg::BANK_KNEE_Q16) ? (bank_abs - rlbhc_pkg::BANK_KNEE_Q16)
                                                          : '0;
      // 15/33 = 5/11: form 5*excess here, divide by 11 through the multiplier
      excess5_in  = {bank_excess, 2'b00} + {2'b00, bank_excess};
   end

   // ------------------------------------------------------------------
   // Shared multiplier and accumulator
   // ------------------------------------------------------------------
   logic signed [35:0] mul_a;
   logic signed [28:0] mul_b;
   logic signed [64:0] prod_ff;
   logic signed [53:0] sum_ff, sum_in;
   logic signed [23:0] rate_dem_ff, limiter_ff;
   logic signed [24:0] bank_dem_ff;
   logic signed [35:0] xi_ff;
   logic signed [25:0] bank_err;
   logic signed [24:0] gain_sum;
   logic [16:0]        stick_share;

   assign bank_err    = 26'(bank_ff) - 26'(bank_dem_ff);
   assign gain_sum    = 25'(bank_prop_gain_ff) + 25'(bank_second_gain_ff);
   assign stick_share = rlbhc_pkg::ONE_Q16 - weight_ff;

   always_comb begin
      case (cw.mul_sel)
         rlbhc_pkg::MUL_RECIP: begin
            mul_a = $signed({9'd0, excess5_ff});
            mul_b = $signed({1'b0, rlbhc_pkg::RECIP_11});
         end
         rlbhc_pkg::MUL_RATE: begin
            mul_a = 36'(rate_dem_ff);
            mul_b = $signed({13'd0, PERIOD_Q16});
         end
         rlbhc_pkg::MUL_DGAIN: begin
            mul_a = 36'(bank_dem_ff);
            mul_b = 29'(bank_demand_gain_ff);
         end
         rlbhc_pkg::MUL_PGAIN: begin
            mul_a = 36'(bank_err);
            mul_b = 29'(gain_sum);
         end
         rlbhc_pkg::MUL_RGAIN: begin
            mul_a = 36'(rate_ff);
            mul_b = 29'(roll_rate_gain_ff);
         end
         rlbhc_pkg::MUL_WXI: begin
            mul_a = xi_ff;
            mul_b = $signed({12'd0, weight_ff});
         end
         rlbhc_pkg::MUL_WSTICK: begin
            mul_a = 36'(stick_ff);
            mul_b = $signed({12'd0, stick_share});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      case (cw.sum_op)
         rlbhc_pkg::SUM_LOAD: sum_in = prod_ff[53:0];
         rlbhc_pkg::SUM_ADD:  sum_in = sum_ff + prod_ff[53:0];
         default:             sum_in = sum_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 65'(mul_a) * 65'(mul_b);
      sum_ff  <= sum_in;
   end

   // ------------------------------------------------------------------
   // Limiter, rate demand, bank demand, control term and blend
   // ------------------------------------------------------------------
   logic [23:0]        quot;
   logic signed [23:0] limiter_in;
   logic signed [22:0] stick15;
   logic signed [24:0] rate_wide;
   logic signed [23:0] rate_dem_in;
   logic signed [64:0] prod_round;
   logic signed [27:0] bank_sum;
   logic signed [24:0] bank_dem_in;
   logic signed [53:0] sum_round;
   logic signed [35:0] xi_in;
   logic signed [37:0] mix_wide;
   logic signed [17:0] mix;

   always_comb begin
      quot       = prod_ff[rlbhc_pkg::RECIP_SHIFT+23:rlbhc_pkg::RECIP_SHIFT];
      // limiter pushes against the bank: negate for positive bank
      limiter_in = (!bank_ff[24] && bank_ff != '0) ? -$signed(quot) : $signed(quot);
      stick15    = (23'(stick_ff) <<< 4) - 23'(stick_ff);
      rate_wide  = 25'(stick15) + 25'(limiter_in);
      if (rate_wide > rlbhc_pkg::RATE_MAX) begin
         rate_dem_in = rate_wide[23:0] & 24'sh7FFFFF | 24'sh7FFFFF;
      end else if (rate_wide < rlbhc_pkg::RATE_MIN) begin
         rate_dem_in = -24'sh800000;
      end else begin
         rate_dem_in = rate_wide[23:0];
      end

      // integrate: round the Q32 product to Q16, nearest with ties up
      prod_round = prod_ff + 65'sd32768;
      bank_sum   = 28'(bank_dem_ff) + 28'($signed(prod_round[40:16]));
      if (bank_sum > rlbhc_pkg::BANK_LIMIT_Q16) begin
         bank_dem_in = 25'(rlbhc_pkg::BANK_LIMIT_Q16);
      end else if (bank_sum < -rlbhc_pkg::BANK_LIMIT_Q16) begin
         bank_dem_in = 25'(-rlbhc_pkg::BANK_LIMIT_Q16);
      end else begin
         bank_dem_in = bank_sum[24:0];
      end
      // full ground mode: track the measured bank
      if (weight_ff == '0) begin
         bank_dem_in = bank_ff;
      end

      sum_round = sum_ff + 54'sd32768;
      xi_in     = sum_round[51:16];
      mix_wide  = sum_round[53:16];
      if (mix_wide > rlbhc_pkg::MIX_MAX) begin
         mix = 18'(rlbhc_pkg::MIX_MAX);
      end else if (mix_wide < rlbhc_pkg::MIX_MIN) begin
         mix = 18'(rlbhc_pkg::MIX_MIN);
      end else begin
         mix = mix_wide[17:0];
      end
   end

   // ------------------------------------------------------------------
   // State and output registers
   // ------------------------------------------------------------------
   logic signed [17:0] out_aileron_ff;
   logic signed [23:0] out_rate_ff, out_limiter_ff;
   logic signed [24:0] out_bank_ff;
   logic [16:0]        out_weight_ff;
   logic               result_load;

   assign result_load  = step_go & (cw.dst == rlbhc_pkg::DST_RESULT);
   assign rsp_valid_in = result_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         weight_ff    <= '0;
         bank_dem_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cw.dst == rlbhc_pkg::DST_WEIGHT) begin
            weight_ff <= weight_in;
         end
         if (cw.dst == rlbhc_pkg::DST_BANKDEM) begin
            bank_dem_ff <= bank_dem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cw.dst == rlbhc_pkg::DST_WEIGHT) begin
         excess5_ff <= excess5_in;
      end
      if (cw.dst == rlbhc_pkg::DST_LIMIT) begin
         limiter_ff  <= limiter_in;
         rate_dem_ff <= rate_dem_in;
      end
      if (cw.dst == rlbhc_pkg::DST_XI) begin
         xi_ff <= xi_in;
      end
      // hold the finished result until taken; the next sample runs behind it
      if (result_load) begin
         out_aileron_ff <= mix;
         out_rate_ff    <= rate_dem_ff;
         out_limiter_ff <= limiter_ff;
         out_bank_ff    <= bank_dem_ff;
         out_weight_ff  <= weight_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_aileron_command = out_aileron_ff;
   assign rsp_rate_demand     = out_rate_ff;
   assign rsp_limiter_term    = out_limiter_ff;
   assign rsp_bank_demand_out = out_bank_ff;
   assign rsp_mode_weight_out = out_weight_ff;

endmodule

>>> design/rlbhc_checker.sv
// Port-level checks for the roll law bank hold controller, bound to the top level.
module rlbhc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [17:0] rsp_aileron_command,
   input logic signed [24:0] rsp_bank_demand_out,
   input logic [16:0]        rsp_mode_weight_out
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_aileron_command)
                                 && $stable(rsp_bank_demand_out))
      else $error("stalled response changed");

   // one request in flight: block stalls right after taking one
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a new result appears only from a busy sequencer
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in flight");

   // blended command stays within +-1.0
   a_aileron_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_aileron_command <= 18'sd65536 && rsp_aileron_command >= -18'sd65536)
      else $error("aileron command out of range");

   // weight never exceeds 1.0
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode_weight_out <= 17'd65536)
      else $error("mode weight out of range");

endmodule

bind roll_law_bank_hold_controller rlbhc_checker u_rlbhc_checker (.*);
